>>> hdl/decision_stump_pixel_classifier_unit_assert.svh
// assertion macros for the decision stump pixel classifier
`ifndef DECISION_STUMP_PIXEL_CLASSIFIER_UNIT_ASSERT_SVH
`define DECISION_STUMP_PIXEL_CLASSIFIER_UNIT_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define DSPC_ASSERT_SAME(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error("same cycle check failed");
`define DSPC_ASSERT_NEXT(label, clk, rst_n, pre, post) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error("next cycle check failed");
`else
`define DSPC_ASSERT_SAME(label, clk, rst_n, pre, post)
`define DSPC_ASSERT_NEXT(label, clk, rst_n, pre, post)
`endif
`endif

>>> hdl/dspc_pkg.sv
// shared types and constants for the decision stump pixel classifier
package dspc_pkg;

	localparam int MAX_STUMPS = 64;
	localparam int LANES = 4;
	localparam int LANE_W = 2;
	localparam int CONTRIB_W = 17;
	localparam int FIT_W = 32;
	localparam int CFG_W = 24;
	localparam int CFG_IDX_W = 1;

	localparam logic CMD_LOAD = 1'b0;
	localparam logic CMD_CLASSIFY = 1'b1;

	localparam logic [CFG_IDX_W-1:0] REG_FIT_OFFSET = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_STUMPS = 1'd1;

	localparam logic [1:0] CH_A = 2'd0;
	localparam logic [1:0] CH_B = 2'd1;
	localparam logic [1:0] CH_C = 2'd2;

	localparam logic [7:0] LABEL_POS = 8'd255;
	localparam logic [7:0] LABEL_NEG = 8'd0;

	typedef struct packed {
		logic               command;
		logic [5:0]         entry_index;
		logic [1:0]         entry_channel;
		logic signed [15:0] entry_threshold;
		logic signed [15:0] entry_weight;
		logic signed [15:0] sample_a;
		logic signed [15:0] sample_b;
		logic signed [15:0] sample_c;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] fit_score;
		logic [7:0]         class_label;
	} out_item_t;

	typedef struct packed {
		logic [1:0]         channel;
		logic signed [15:0] threshold;
		logic signed [15:0] weight;
	} stump_t;

	typedef struct packed {
		logic signed [15:0] a;
		logic signed [15:0] b;
		logic signed [15:0] c;
	} pixel_t;

	typedef struct packed {
		logic init;
		logic add;
	} merge_ctl_t;

endpackage

>>> hdl/dspc_ram.sv
// generic simple dual port ram with registered read
module dspc_ram #(
	parameter int WIDTH = 34,
	parameter int DEPTH = 16,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

>>> hdl/dspc_lane.sv
// one stump lane: channel select, threshold compare, registered contribution
module dspc_lane (
	input  logic                                   clk,
	input  logic                                   en,
	input  dspc_pkg::stump_t                       stump,
	input  dspc_pkg::pixel_t                       pixel,
	output logic signed [dspc_pkg::CONTRIB_W-1:0]  contrib_s2
);

	logic signed [15:0] sel;
	logic               sel_ok;
	logic               hit;

	always_comb begin
		sel = pixel.a;
		sel_ok = 1'b1;
		case (stump.channel)
			dspc_pkg::CH_A: sel = pixel.a;
			dspc_pkg::CH_B: sel = pixel.b;
			dspc_pkg::CH_C: sel = pixel.c;
			default: sel_ok = 1'b0;
		endcase
		hit = en && sel_ok && (sel < stump.threshold);
	end

	always_ff @(posedge clk) begin
		contrib_s2 <= hit ? -dspc_pkg::CONTRIB_W'(stump.weight) : '0;
	end

endmodule

>>> hdl/dspc_merge.sv
// merge stage: loads the negated fit offset on init, then sums the lane contributions into the fit accumulator
module dspc_merge (
	input  logic                                  clk,
	input  dspc_pkg::merge_ctl_t                  ctl,
	input  logic signed [dspc_pkg::CFG_W-1:0]     offset,
	input  logic signed [dspc_pkg::CONTRIB_W-1:0] contrib [dspc_pkg::LANES],
	output logic signed [dspc_pkg::FIT_W-1:0]     acc_q
);

	localparam int SUM_W = dspc_pkg::CONTRIB_W + dspc_pkg::LANE_W;

	logic signed [SUM_W-1:0] sum;

	always_comb begin
		sum = '0;
		for (int l = 0; l < dspc_pkg::LANES; l++) begin
			sum = sum + SUM_W'(contrib[l]);
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.init) begin
			acc_q <= -dspc_pkg::FIT_W'(offset);
		end else if (ctl.add) begin
			acc_q <= acc_q + dspc_pkg::FIT_W'(sum);
		end
	end

endmodule

>>> hdl/decision_stump_pixel_classifier_unit.sv
// top level of the decision stump pixel classifier
//
// channel  signals                          width     notes
// in       in_valid in_ready in_data        in_item   load or classify word
// out      out_valid out_ready out_data     out_item  one word per classify
// cfg      cfg_we cfg_index cfg_data        24 bits   fit_offset, active_stumps
//
// the table sits in LANES banks, one row of LANES stumps read per cycle
// a load is written into its bank as it is accepted; a classify of n active stumps reads ceil(n/LANES) rows
// in the bank read loop, then passes the read, lane and merge stages (straight to emit when n is 0)
// after reset a clearing pass zeroes the banks one row at a time, ceil(MAX_STUMPS/LANES) rows (16 by default),
// during which no word is accepted; config writes are taken at any time
// a finished result waits in the output register while new load and classify words are still accepted
`include "decision_stump_pixel_classifier_unit_assert.svh"
module decision_stump_pixel_classifier_unit #(
	parameter int MAX_STUMPS = dspc_pkg::MAX_STUMPS
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  dspc_pkg::in_item_t                 in_data,
	output logic                               out_valid,
	input  logic                               out_ready,
	output dspc_pkg::out_item_t                out_data,
	input  logic                               cfg_we,
	input  logic [dspc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [dspc_pkg::CFG_W-1:0]         cfg_data
);

	localparam int LANES = dspc_pkg::LANES;
	localparam int LANE_W = dspc_pkg::LANE_W;
	localparam int ROWS = (MAX_STUMPS + LANES - 1) / LANES;
	localparam int ROW_W = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CNT_W = $clog2(MAX_STUMPS + 1);
	localparam int ENTRY_W = $bits(dspc_pkg::stump_t);

	typedef enum logic [4:0] {
		ST_CLEAR = 5'b00001,
		ST_IDLE  = 5'b00010,
		ST_RUN   = 5'b00100,
		ST_DRAIN = 5'b01000,
		ST_EMIT  = 5'b10000
	} state_t;

	state_t                          state_q;
	logic [ROW_W-1:0]                row_q;
	logic [CNT_W-1:0]                rem_q;
	logic [CNT_W-1:0]                cnt_sat;
	logic signed [dspc_pkg::CFG_W-1:0] offset_q;
	logic [6:0]                      active_q;
	dspc_pkg::pixel_t                pixel_q;
	logic                            in_acc;
	logic                            load_acc;
	logic                            cls_acc;
	logic                            load_ok;
	logic                            rd_en;
	logic                            row_last;
	logic                            valid_s1;
	logic                            last_s1;
	logic [LANES-1:0]                mask_s1;
	logic                            valid_s2;
	logic                            last_s2;
	logic                            out_free;
	logic                            out_valid_q;
	dspc_pkg::out_item_t             out_q;
	dspc_pkg::merge_ctl_t            merge_ctl;
	dspc_pkg::stump_t                wr_entry;
	logic [ROW_W-1:0]                wr_row;
	logic signed [dspc_pkg::CONTRIB_W-1:0] contrib [LANES];
	logic signed [dspc_pkg::FIT_W-1:0]     acc;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc = in_valid && in_ready;
	assign load_acc = in_acc && (in_data.command == dspc_pkg::CMD_LOAD);
	assign cls_acc = in_acc && (in_data.command == dspc_pkg::CMD_CLASSIFY);
	assign load_ok = load_acc && (32'(in_data.entry_index) < MAX_STUMPS);
	assign rd_en = (state_q == ST_RUN);
	assign row_last = (32'(rem_q) <= LANES);
	assign out_free = !out_valid_q || out_ready;
	assign cnt_sat = (32'(active_q) > MAX_STUMPS) ? CNT_W'(MAX_STUMPS) : CNT_W'(active_q);

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= '0;
			active_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				dspc_pkg::REG_FIT_OFFSET: offset_q <= cfg_data;
				dspc_pkg::REG_ACTIVE_STUMPS: active_q <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			row_q <= '0;
			rem_q <= '0;
		end else begin
			unique case (state_q)
				ST_CLEAR: begin
					if (row_q == ROW_W'(ROWS - 1)) begin
						state_q <= ST_IDLE;
						row_q <= '0;
					end else begin
						row_q <= row_q + ROW_W'(1);
					end
				end
				ST_IDLE: begin
					if (cls_acc) begin
						row_q <= '0;
						rem_q <= cnt_sat;
						state_q <= (cnt_sat == '0) ? ST_EMIT : ST_RUN;
					end
				end
				ST_RUN: begin
					if (row_last) begin
						state_q <= ST_DRAIN;
					end else begin
						rem_q <= rem_q - CNT_W'(LANES);
						row_q <= row_q + ROW_W'(1);
					end
				end
				ST_DRAIN: begin
					if (valid_s2 && last_s2) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (cls_acc) begin
			pixel_q <= '{a: in_data.sample_a, b: in_data.sample_b, c: in_data.sample_c};
		end
	end

	// pipeline control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			last_s1 <= 1'b0;
			mask_s1 <= '0;
			valid_s2 <= 1'b0;
			last_s2 <= 1'b0;
		end else begin
			valid_s1 <= rd_en;
			last_s1 <= rd_en && row_last;
			for (int l = 0; l < LANES; l++) begin
				mask_s1[l] <= rd_en && (32'(rem_q) > l);
			end
			valid_s2 <= valid_s1;
			last_s2 <= last_s1;
		end
	end

	// table write: clearing pass or load word
	always_comb begin
		if (state_q == ST_CLEAR) begin
			wr_entry = '0;
			wr_row = row_q;
		end else begin
			wr_entry = '{channel: in_data.entry_channel, threshold: in_data.entry_threshold,
				weight: in_data.entry_weight};
			wr_row = ROW_W'(in_data.entry_index >> LANE_W);
		end
	end

	for (genvar b = 0; b < LANES; b++) begin : g_lane
		logic             bank_we;
		logic [ENTRY_W-1:0] bank_rdata;

		assign bank_we = (state_q == ST_CLEAR) ||
			(load_ok && (in_data.entry_index[LANE_W-1:0] == LANE_W'(b)));

		dspc_ram #(
			.WIDTH(ENTRY_W),
			.DEPTH(ROWS)
		) u_bank (
			.clk  (clk),
			.we   (bank_we),
			.waddr(wr_row),
			.wdata(wr_entry),
			.re   (rd_en),
			.raddr(row_q),
			.rdata(bank_rdata)
		);

		dspc_lane u_lane (
			.clk       (clk),
			.en        (mask_s1[b]),
			.stump     (dspc_pkg::stump_t'(bank_rdata)),
			.pixel     (pixel_q),
			.contrib_s2(contrib[b])
		);
	end

	assign merge_ctl = '{init: cls_acc, add: valid_s2};

	dspc_merge u_merge (
		.clk    (clk),
		.ctl    (merge_ctl),
		.offset (offset_q),
		.contrib(contrib),
		.acc_q  (acc)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EMIT && out_free) begin
			out_q.fit_score <= acc;
			out_q.class_label <= (acc > 0) ? dspc_pkg::LABEL_POS : dspc_pkg::LABEL_NEG;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data = out_q;

	`DSPC_ASSERT_NEXT(a_last_row_ends, clk, arst_n, valid_s2 && last_s2, state_q == ST_EMIT)
	`DSPC_ASSERT_NEXT(a_classify_busy, clk, arst_n, cls_acc, state_q != ST_IDLE)
	`DSPC_ASSERT_NEXT(a_emit_shows, clk, arst_n, state_q == ST_EMIT && out_free, out_valid)
	`DSPC_ASSERT_SAME(a_no_read_idle, clk, arst_n, valid_s1, state_q == ST_RUN || state_q == ST_DRAIN)

endmodule

>>> dv/decision_stump_pixel_classifier_unit_tb.sv
// self-checking testbench for the decision stump pixel classifier: directed edges, random mix, full rate
`timescale 1ns / 1ps
module decision_stump_pixel_classifier_unit_tb;

	localparam logic [1:0] CH_NONE = 2'd3;
	localparam int SETTLE_CYCLES = 40;
	localparam int STALL_LIMIT = 2000;
	localparam int RANDOM_PHASES = 14;
	localparam int PHASE_WORDS = 100;
	localparam int FULL_RATE_WORDS = 250;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	dspc_pkg::in_item_t in_data;
	logic out_valid;
	logic out_ready = 1'b0;
	dspc_pkg::out_item_t out_data;
	logic cfg_we;
	logic [dspc_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [dspc_pkg::CFG_W-1:0] cfg_data;

	dspc_pkg::stump_t tbl_stumps [dspc_pkg::MAX_STUMPS];
	logic signed [23:0] cur_offset;
	logic [6:0] cur_active;
	dspc_pkg::out_item_t pending_scores [$];
	dspc_pkg::out_item_t want;

	bit idle_on;
	int errors;
	int n_classify;
	int n_load;
	int n_writes;
	int out_burst;
	int quiet_cycles;

	decision_stump_pixel_classifier_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	function automatic dspc_pkg::out_item_t score_pixel(input dspc_pkg::pixel_t px);
		dspc_pkg::out_item_t r;
		longint fit;
		int n;
		logic signed [15:0] s;
		bit hit;
		fit = -longint'(cur_offset);
		n = (cur_active > dspc_pkg::MAX_STUMPS) ? dspc_pkg::MAX_STUMPS : int'(cur_active);
		for (int k = 0; k < n; k++) begin
			hit = 1'b1;
			case (tbl_stumps[k].channel)
				dspc_pkg::CH_A: s = px.a;
				dspc_pkg::CH_B: s = px.b;
				dspc_pkg::CH_C: s = px.c;
				default: begin
					s = '0;
					hit = 1'b0;
				end
			endcase
			if (hit && int'(s) < int'(tbl_stumps[k].threshold))
				fit -= longint'(tbl_stumps[k].weight);
		end
		r.fit_score = fit[31:0];
		r.class_label = (fit > 0) ? dspc_pkg::LABEL_POS : dspc_pkg::LABEL_NEG;
		return r;
	endfunction

	function automatic dspc_pkg::in_item_t random_word();
		dspc_pkg::in_item_t w;
		int k;
		int lim;
		w.command = ($urandom_range(0, 9) < 4) ? dspc_pkg::CMD_LOAD : dspc_pkg::CMD_CLASSIFY;
		w.entry_index = 6'($urandom);
		w.entry_channel = 2'($urandom_range(0, 3));
		w.entry_threshold = 16'($urandom);
		w.entry_weight = 16'($urandom);
		w.sample_a = 16'($urandom);
		w.sample_b = 16'($urandom);
		w.sample_c = 16'($urandom);
		lim = (cur_active > dspc_pkg::MAX_STUMPS) ? dspc_pkg::MAX_STUMPS : int'(cur_active);
		if (lim > 0 && $urandom_range(0, 1) == 0)
			w.entry_index = 6'($urandom_range(0, lim - 1));
		if (w.command == dspc_pkg::CMD_CLASSIFY && $urandom_range(0, 3) == 0) begin
			k = $urandom_range(0, dspc_pkg::MAX_STUMPS - 1);
			case (tbl_stumps[k].channel)
				dspc_pkg::CH_A: w.sample_a = tbl_stumps[k].threshold;
				dspc_pkg::CH_B: w.sample_b = tbl_stumps[k].threshold;
				dspc_pkg::CH_C: w.sample_c = tbl_stumps[k].threshold;
				default: ;
			endcase
		end
		if ($urandom_range(0, 15) == 0)
			w.sample_a = $urandom_range(0, 1) ? 16'h8000 : 16'h7fff;
		return w;
	endfunction

	task automatic send_word(input dspc_pkg::in_item_t w);
		int gap;
		gap = 0;
		if (idle_on && $urandom_range(0, 5) == 0)
			gap = $urandom_range(1, 14);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= w;
		do @(posedge clk); while (!in_ready);
		if (w.command == dspc_pkg::CMD_CLASSIFY) begin
			pending_scores.push_back(score_pixel(dspc_pkg::pixel_t'{w.sample_a, w.sample_b,
				w.sample_c}));
			n_classify++;
		end else begin
			tbl_stumps[w.entry_index] = dspc_pkg::stump_t'{w.entry_channel, w.entry_threshold,
				w.entry_weight};
			n_load++;
		end
	endtask

	task automatic send_load(input logic [5:0] idx, input logic [1:0] ch,
			input logic [15:0] thr, input logic [15:0] wt);
		dspc_pkg::in_item_t w;
		w = '0;
		w.command = dspc_pkg::CMD_LOAD;
		w.entry_index = idx;
		w.entry_channel = ch;
		w.entry_threshold = thr;
		w.entry_weight = wt;
		w.sample_a = 16'($urandom);
		w.sample_b = 16'($urandom);
		w.sample_c = 16'($urandom);
		send_word(w);
	endtask

	task automatic send_pixel(input logic [15:0] a, input logic [15:0] b, input logic [15:0] c);
		dspc_pkg::in_item_t w;
		w.command = dspc_pkg::CMD_CLASSIFY;
		w.entry_index = 6'($urandom);
		w.entry_channel = 2'($urandom);
		w.entry_threshold = 16'($urandom);
		w.entry_weight = 16'($urandom);
		w.sample_a = a;
		w.sample_b = b;
		w.sample_c = c;
		send_word(w);
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (pending_scores.size() > 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [dspc_pkg::CFG_IDX_W-1:0] idx,
			input logic [dspc_pkg::CFG_W-1:0] data);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		cfg_we <= 1'b0;
		@(posedge clk);
		if (idx == dspc_pkg::REG_FIT_OFFSET)
			cur_offset = data;
		else if (idx == dspc_pkg::REG_ACTIVE_STUMPS)
			cur_active = data[6:0];
		n_writes++;
	endtask

	task automatic write_active(input int n);
		logic [dspc_pkg::CFG_W-1:0] data;
		data = dspc_pkg::CFG_W'($urandom);
		data[6:0] = 7'(n);
		write_reg(dspc_pkg::REG_ACTIVE_STUMPS, data);
	endtask

	task automatic pick_random_config();
		logic [dspc_pkg::CFG_W-1:0] off;
		logic [31:0] r;
		int sel;
		r = $urandom;
		sel = $urandom_range(0, 7);
		case (sel)
			0: off = 24'h800000;
			1: off = 24'h7fffff;
			2: off = dspc_pkg::CFG_W'(r);
			default: off = {{5{r[18]}}, r[18:0]};
		endcase
		write_reg(dspc_pkg::REG_FIT_OFFSET, off);
		sel = $urandom_range(0, 7);
		case (sel)
			0: write_active(0);
			1: write_active(dspc_pkg::MAX_STUMPS);
			2: write_active($urandom_range(dspc_pkg::MAX_STUMPS + 1, 127));
			default: write_active($urandom_range(1, dspc_pkg::MAX_STUMPS - 1));
		endcase
	endtask

	task automatic test_cleared_table();
		send_pixel(16'h8000, 16'h8000, 16'h8000);
		send_pixel(16'h7fff, 16'h7fff, 16'h7fff);
		wait_idle();
		write_active(dspc_pkg::MAX_STUMPS);
		send_pixel(16'h8000, 16'h8000, 16'h8000);
		send_pixel(16'h7fff, 16'h0000, 16'hffff);
		wait_idle();
	endtask

	task automatic test_stump_edges();
		send_load(6'd0, dspc_pkg::CH_A, 16'h7fff, 16'h8000);
		send_load(6'd1, dspc_pkg::CH_B, 16'h8000, 16'h7fff);
		send_load(6'd2, dspc_pkg::CH_C, 16'd100, 16'd5);
		send_load(6'd3, CH_NONE, 16'h7fff, 16'd1234);
		send_load(6'd63, dspc_pkg::CH_A, 16'h7fff, 16'h7fff);
		send_pixel(16'h8000, 16'h8000, 16'd100);
		send_pixel(16'h8000, 16'h8000, 16'd99);
		send_pixel(16'h7fff, 16'h7fff, 16'h7fff);
		send_pixel(16'h7ffe, 16'h8001, 16'h8000);
		wait_idle();
	endtask

	task automatic test_config_extremes();
		write_reg(dspc_pkg::REG_FIT_OFFSET, 24'h7fffff);
		write_active(dspc_pkg::MAX_STUMPS + 1);
		send_pixel(16'h8000, 16'h0000, 16'h0000);
		wait_idle();
		write_reg(dspc_pkg::REG_FIT_OFFSET, 24'h800000);
		write_active(127);
		send_pixel(16'h8000, 16'h8000, 16'h8000);
		wait_idle();
		write_reg(dspc_pkg::REG_FIT_OFFSET, 24'hffffff);
		write_active(0);
		send_pixel(16'h0000, 16'h0000, 16'h0000);
		wait_idle();
		write_reg(dspc_pkg::REG_FIT_OFFSET, 24'h000000);
		write_active(4);
		send_pixel(16'h7fff, 16'h8000, 16'd99);
		wait_idle();
	endtask

	task automatic test_random_mix();
		for (int p = 0; p < RANDOM_PHASES; p++) begin
			pick_random_config();
			for (int i = 0; i < PHASE_WORDS; i++)
				send_word(random_word());
			wait_idle();
		end
	endtask

	task automatic test_full_rate();
		idle_on = 1'b0;
		pick_random_config();
		for (int i = 0; i < FULL_RATE_WORDS; i++)
			send_word(random_word());
		wait_idle();
	endtask

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_scores.size() == 0) begin
				$error("result word with nothing expected: fit_score %0d class_label %0d",
					out_data.fit_score, out_data.class_label);
				errors++;
			end else begin
				want = pending_scores.pop_front();
				if (out_data.fit_score !== want.fit_score) begin
					$error("fit_score: expected %0d, actual %0d", want.fit_score,
						out_data.fit_score);
					errors++;
				end
				if (out_data.class_label !== want.class_label) begin
					$error("class_label: expected %0d, actual %0d", want.class_label,
						out_data.class_label);
					errors++;
				end
			end
		end
		if (out_burst > 0) begin
			out_burst <= out_burst - 1;
			out_ready <= 1'b0;
		end else if (idle_on && $urandom_range(0, 7) == 0) begin
			out_burst <= $urandom_range(1, 14) - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= STALL_LIMIT) begin
				$display("status: fail");
				$finish;
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		cfg_we = 1'b0;
		cfg_index = dspc_pkg::REG_FIT_OFFSET;
		cfg_data = '0;
		idle_on = 1'b1;
		errors = 0;
		n_classify = 0;
		n_load = 0;
		n_writes = 0;
		out_burst = 0;
		quiet_cycles = 0;
		cur_offset = '0;
		cur_active = '0;
		for (int k = 0; k < dspc_pkg::MAX_STUMPS; k++)
			tbl_stumps[k] = '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_cleared_table();
		test_stump_edges();
		test_config_extremes();
		test_random_mix();
		test_full_rate();
		wait_idle();

		$display("covered %0d classify words and %0d table loads across %0d register writes",
			n_classify, n_load, n_writes);
		$display("random idling on both channels, then a stretch at full rate; %0d mismatches",
			errors);
		if (errors == 0 && pending_scores.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

endmodule
